/* design/nghri_pkg.sv */
// nghri_pkg: shared constants, types and width helpers for the n-gram hash row index block
// no dependencies
package nghri_pkg;

  localparam int unsigned NgramSizeDef     = 3;
  localparam int unsigned HeadsPerOrderDef = 8;
  localparam int unsigned TotalHeadsDef    = 16;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned MaxOut     = 16;
  localparam int unsigned HeadW      = 4;
  localparam int unsigned TokW       = 32;
  localparam int unsigned ModW       = 32;
  localparam int unsigned OffW       = 31;
  localparam int unsigned EosW       = 31;
  localparam int unsigned HashW      = 64;
  localparam int unsigned CfgW       = 64;
  localparam int unsigned CfgIdxW    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EOS  = 2'd0,
    REG_MUL0 = 2'd1,
    REG_MUL1 = 2'd2,
    REG_MUL2 = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_TOKEN = 1'b1
  } cmd_e;

  typedef struct packed {
    logic            command;
    logic [TokW-1:0] token;
    logic [TokW-1:0] prev_newer;
    logic [TokW-1:0] prev_older;
    logic [HeadW-1:0] head_index;
    logic [ModW-1:0] head_modulus;
    logic [OffW-1:0] head_offset;
    logic            final_token;
  } in_item_t;

  typedef struct packed {
    logic [HeadW-1:0] head;
    logic [TokW-1:0]  row;
    logic             last_of_token;
    logic             final_of_batch;
  } out_item_t;

  // classified token entry between front and back
  typedef struct packed {
    logic [HashW-1:0] ctx0;
    logic [HashW-1:0] ctx1;
    logic [HashW-1:0] ctx2;
    logic             final_token;
  } tok_entry_t;

endpackage

/* design/nghri_stream_if.sv */
// nghri_stream_if: valid/ready channel carrying one payload of parameterized type
// depends on nothing
interface nghri_stream_if #(
  parameter type PayloadT = logic
);
  logic    valid;
  logic    ready;
  PayloadT data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/ngram_hash_row_index_top.sv */
// ngram_hash_row_index_top: top level, front classifier, head table RAM, back hasher
// depends on nghri_pkg, nghri_stream_if, nghri_front, nghri_ram, nghri_back
//
// usage:
//   in_if carries load items (command 0) and token items (command 1), valid/ready.
//   a load item writes one head table entry and gives no result; it is held off
//   until no token is queued or in the back end.
//   a token item gives TotalHeads results (at most MaxOut) on out_if in head order; the last
//   carries last_of_token and, if the token was marked, final_of_batch.
//   configuration: cfg_we_i/cfg_idx_i/cfg_data_i write eos and the multipliers; the user
//   must write them only while the block is idle, which the block does not enforce.
// sequence:
//   a token is taken, then hashed as three 64-bit products, each three 32x32
//   partial products with a registered product; then per head: table read,
//   64 remainder steps, output (no remainder steps if modulus is 0).
//   the back end takes the next token only after the last head's output.
//   a two-entry queue sits between the front and the hashing back end.
// reset: queue and sequencers empty, configuration registers zero; table entries undefined.
// when the receiver stalls the output register holds and the back end waits.
module ngram_hash_row_index_top import nghri_pkg::*; #(
  parameter int unsigned NgramSize     = NgramSizeDef,
  parameter int unsigned HeadsPerOrder = HeadsPerOrderDef,
  parameter int unsigned TotalHeads    = TotalHeadsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  nghri_stream_if.sink        in_if,
  nghri_stream_if.source      out_if
);
  logic [EosW-1:0] eos_q;
  logic [HashW-1:0] mul0_q, mul1_q, mul2_q;
  logic tbl_we, tbl_re;
  logic [HeadW-1:0] tbl_widx, tbl_ridx;
  logic [ModW+OffW-1:0] tbl_wdata, tbl_rdata;
  logic q_valid, q_ready;
  tok_entry_t q_data;
  in_item_t in_data;
  out_item_t out_data;

  assign in_data = in_if.data;
  assign out_if.data = out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eos_q <= '0;
      mul0_q <= '0;
      mul1_q <= '0;
      mul2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_EOS:  eos_q <= cfg_data_i[EosW-1:0];
        REG_MUL0: mul0_q <= cfg_data_i;
        REG_MUL1: mul1_q <= cfg_data_i;
        REG_MUL2: mul2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nghri_front u_front (
    .clk_i, .rst_ni, .eos_i(eos_q),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_data),
    .tbl_we_o(tbl_we), .tbl_idx_o(tbl_widx), .tbl_wdata_o(tbl_wdata),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  nghri_ram #(.Width(ModW + OffW), .Depth(TableDepth)) u_table (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_widx), .wdata_i(tbl_wdata),
    .re_i(tbl_re), .raddr_i(tbl_ridx), .rdata_o(tbl_rdata)
  );

  nghri_back #(
    .NgramSize(NgramSize), .HeadsPerOrder(HeadsPerOrder), .TotalHeads(TotalHeads)
  ) u_back (
    .clk_i, .rst_ni, .mul0_i(mul0_q), .mul1_i(mul1_q), .mul2_i(mul2_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .tbl_re_o(tbl_re), .tbl_raddr_o(tbl_ridx), .tbl_rdata_i(tbl_rdata),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_data)
  );

  // final_of_batch only with last_of_token
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_data.final_of_batch |-> out_data.last_of_token)
    else $error("final without last");

  // a table write only comes from a load item
  a_load_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> in_data.command == CMD_LOAD)
    else $error("table write on token");

  // back end takes no token while a result stalls mid-token
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready && !out_data.last_of_token |=> !q_ready)
    else $error("back end idle mid-token");
endmodule

/* design/nghri_front.sv */
// nghri_front: accepts items, writes head table, builds the context, and queues tokens
// depends on nghri_pkg
module nghri_front import nghri_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [EosW-1:0]    eos_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               tbl_we_o,
  output logic [HeadW-1:0]   tbl_idx_o,
  output logic [ModW+OffW-1:0] tbl_wdata_o,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output tok_entry_t         q_data_o
);
  // two-entry queue
  tok_entry_t mem_q [2];
  logic       wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  tok_entry_t ent;
  logic       cut1, cut2;
  logic [HashW-1:0] eos64;

  // a load waits until no token is queued or in the back end (q_ready_i is its idle)
  assign in_ready_o = (in_data_i.command == CMD_TOKEN) ? (cnt_q != 2'd2)
                                                       : ((cnt_q == 2'd0) && q_ready_i);
  assign eos64 = {{(HashW-EosW){1'b0}}, eos_i};
  assign cut1 = in_data_i.prev_newer[TokW-1] ||
                (in_data_i.prev_newer == {1'b0, eos_i});
  assign cut2 = cut1 || in_data_i.prev_older[TokW-1] ||
                (in_data_i.prev_older == {1'b0, eos_i});

  always_comb begin
    ent.ctx0 = {{(HashW-TokW){in_data_i.token[TokW-1]}}, in_data_i.token};
    ent.ctx1 = cut1 ? eos64 : {{(HashW-TokW){1'b0}}, in_data_i.prev_newer};
    ent.ctx2 = cut2 ? eos64 : {{(HashW-TokW){1'b0}}, in_data_i.prev_older};
    ent.final_token = in_data_i.final_token;
  end

  assign tbl_we_o = in_valid_i && in_ready_o && (in_data_i.command == CMD_LOAD);
  assign tbl_idx_o = in_data_i.head_index;
  assign tbl_wdata_o = {in_data_i.head_modulus, in_data_i.head_offset};

  assign push = in_valid_i && in_ready_o && (in_data_i.command == CMD_TOKEN);
  assign pop  = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rp_q];

  always_comb begin
    wp_d = push ? ~wp_q : wp_q;
    rp_d = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= ent;
    end
  end
endmodule

/* design/nghri_ram.sv */
// nghri_ram: generic single-write, single-read RAM with registered read
// no dependencies
module nghri_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

/* design/nghri_back.sv */
// nghri_back: per-token hashing and per-head remainder, one bit-serial divider
// depends on nghri_pkg
module nghri_back import nghri_pkg::*; #(
  parameter int unsigned NgramSize     = NgramSizeDef,
  parameter int unsigned HeadsPerOrder = HeadsPerOrderDef,
  parameter int unsigned TotalHeads    = TotalHeadsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [HashW-1:0]     mul0_i,
  input  logic [HashW-1:0]     mul1_i,
  input  logic [HashW-1:0]     mul2_i,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  tok_entry_t           q_data_i,
  output logic                 tbl_re_o,
  output logic [HeadW-1:0]     tbl_raddr_o,
  input  logic [ModW+OffW-1:0] tbl_rdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);
  localparam int unsigned NHeads = (TotalHeads > MaxOut) ? MaxOut : TotalHeads;
  localparam int unsigned Hashed = (NgramSize - 1) * HeadsPerOrder;
  localparam int unsigned HashedCap = (Hashed > NHeads) ? NHeads : Hashed;
  localparam int unsigned HcW    = $clog2(MaxOut + 1);
  localparam logic [HcW-1:0] LastHead = HcW'(NHeads - 1);
  localparam logic [HcW-1:0] HashedC  = HcW'(HashedCap);
  localparam logic [HcW-1:0] HpoC     = HcW'(HeadsPerOrder);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_MULB = 3'd5;

  logic [2:0] state_q, state_d;
  logic [HcW-1:0] head_q, head_d;
  logic [1:0] mstep_q, mstep_d;
  logic [HashW-1:0] ctx_q [3];
  logic [HashW-1:0] hash2_q, hash3_q;
  logic [HashW-1:0] acc_sum;
  logic final_q;
  // 64x64 mod 2^64 as three 32x32 partial products over steps
  logic [1:0] pstep_q, pstep_d;
  logic [HashW-1:0] acc_q, acc_d;
  logic [HashW-1:0] ma, mb;
  logic [31:0] pa, pb;
  logic [HashW-1:0] pp;
  logic [HashW-1:0] pp_q;
  // divider
  logic [HashW-1:0] dvd_q, dvd_d;
  logic [ModW:0] rem_q, rem_d;
  logic [6:0] bit_q, bit_d;
  logic [ModW-1:0] tbl_mod;
  logic [OffW-1:0] tbl_off;
  logic [ModW:0] rsh;
  logic [HashW-1:0] hsel;
  logic out_v_q;
  out_item_t out_q;
  logic take;

  assign q_ready_o = (state_q == S_IDLE);
  assign take = q_valid_i && q_ready_o;
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;
  assign tbl_raddr_o = head_q[HeadW-1:0];
  assign tbl_re_o = (state_q == S_HEAD);
  assign hsel = (head_q >= HpoC) ? hash3_q : hash2_q;

  // modulus/offset from registered table read (valid the cycle after S_HEAD)
  assign tbl_mod = tbl_rdata_i[ModW+OffW-1:OffW];
  assign tbl_off = tbl_rdata_i[OffW-1:0];

  always_comb begin
    unique case (mstep_q)
      2'd0: begin ma = ctx_q[0]; mb = mul0_i; end
      2'd1: begin ma = ctx_q[1]; mb = mul1_i; end
      default: begin ma = ctx_q[2]; mb = mul2_i; end
    endcase
    unique case (pstep_q)
      2'd0: begin pa = ma[31:0];  pb = mb[31:0];  end
      2'd1: begin pa = ma[63:32]; pb = mb[31:0];  end
      default: begin pa = ma[31:0]; pb = mb[63:32]; end
    endcase
    pp = {32'd0, pa} * {32'd0, pb};
  end

  assign acc_sum = (pstep_q == 2'd0) ? (acc_q + pp_q) : (acc_q + {pp_q[31:0], 32'd0});
  assign rsh = {rem_q[ModW-1:0], dvd_q[HashW-1]};

  always_comb begin
    state_d = state_q;
    head_d = head_q;
    mstep_d = mstep_q;
    pstep_d = pstep_q;
    acc_d = acc_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    bit_d = bit_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_MUL;
          mstep_d = 2'd0;
          pstep_d = 2'd0;
          acc_d = '0;
        end
      end
      S_MUL: begin
        // issue partial product; registered then accumulated in S_MULB
        state_d = S_MULB;
      end
      S_MULB: begin
        acc_d = acc_sum;
        if (pstep_q == 2'd2) begin
          pstep_d = 2'd0;
          acc_d = '0;
          if (mstep_q == 2'(NgramSize - 1) || mstep_q == 2'd2) begin
            state_d = S_HEAD;
            head_d = '0;
          end else begin
            mstep_d = mstep_q + 2'd1;
            state_d = S_MUL;
          end
        end else begin
          pstep_d = pstep_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_HEAD: begin
        state_d = S_DIV;
        dvd_d = hsel;
        rem_d = '0;
        bit_d = 7'd0;
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle; zero modulus keeps the hash
        if (tbl_mod == '0) begin
          state_d = S_OUT;
        end else begin
          dvd_d = {dvd_q[HashW-2:0], 1'b0};
          rem_d = (rsh >= {1'b0, tbl_mod}) ? rsh - {1'b0, tbl_mod} : rsh;
          bit_d = bit_q + 7'd1;
          if (bit_q == 7'd63) state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_v_q || out_ready_i) begin
          if (head_q == LastHead) begin
            state_d = S_IDLE;
          end else begin
            head_d = head_q + HcW'(1);
            state_d = S_HEAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= '0;
      mstep_q <= '0;
      pstep_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      mstep_q <= mstep_d;
      pstep_q <= pstep_d;
      if (state_q == S_OUT && (!out_v_q || out_ready_i)) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    bit_q <= bit_d;
    if (state_q == S_MUL) pp_q <= pp;
    if (take) begin
      ctx_q[0] <= q_data_i.ctx0;
      ctx_q[1] <= q_data_i.ctx1;
      ctx_q[2] <= q_data_i.ctx2;
      final_q <= q_data_i.final_token;
    end
    if (state_q == S_MULB && pstep_q == 2'd2) begin
      if (mstep_q == 2'd0) hash2_q <= acc_sum;
      else if (mstep_q == 2'd1) hash2_q <= hash2_q ^ acc_sum;
      if (mstep_q == 2'd0) hash3_q <= acc_sum;
      else hash3_q <= hash3_q ^ acc_sum;
    end
    if (state_q == S_OUT && (!out_v_q || out_ready_i)) begin
      out_q.head <= head_q[HeadW-1:0];
      if (head_q < HashedC) begin
        out_q.row <= (tbl_mod == '0) ? (dvd_q[31:0] + {1'b0, tbl_off})
                                      : (rem_q[31:0] + {1'b0, tbl_off});
      end else begin
        out_q.row <= '0;
      end
      out_q.last_of_token <= (head_q == LastHead);
      out_q.final_of_batch <= (head_q == LastHead) && final_q;
    end
  end
endmodule
